// File: rtl/core/jsonesc_pkg.sv
// Shared types and constants for the JSON string escaper and UTF-8 encoder.
package jsonesc_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int LIMIT_WIDTH = 32;
   localparam int CALC_WIDTH  = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
   localparam logic [CALC_WIDTH-1:0] COUNT_MAX =
      CALC_WIDTH'((65'd1 << COUNT_WIDTH) - 65'd1);

   localparam int CP_WIDTH    = 21;
   localparam int RUN_BYTES   = 8;
   localparam int IDX_WIDTH   = $clog2(RUN_BYTES);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_MALFORMED = 2'd1,
      STATUS_LIMIT     = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      CSR_OUTPUT_BYTE_LIMIT = 1'b0,
      CSR_WORK_LIMIT        = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      logic                starts_string;
      logic                ends_string;
      logic                empty_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      status_type status;
   } rsp_type;

   // All results of one item: bytes, index of the final result, final status.
   typedef struct packed {
      logic [RUN_BYTES-1:0][7:0] bytes;
      logic [IDX_WIDTH-1:0]      last_idx;
      status_type                status;
   } run_type;

endpackage

// File: rtl/core/jsonesc_front.sv
// Front end: accepts items, checks limits and scalars, builds each item's byte run.
module jsonesc_front import jsonesc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  csr_index_type          csr_index,
   input  logic [LIMIT_WIDTH-1:0] csr_data,
   input  logic                   queue_space,
   output logic                   push,
   output run_type                push_data
);

   logic [LIMIT_WIDTH-1:0] output_byte_limit_ff, output_byte_limit_in;
   logic [LIMIT_WIDTH-1:0] work_limit_ff, work_limit_in;
   logic [COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic [COUNT_WIDTH-1:0] work_count_ff, work_count_in;
   status_type             error_latched_ff, error_latched_in;

   logic [5:0][7:0] esc;
   logic [2:0]      esc_len;
   logic [CP_WIDTH-1:0] cp;

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      hex_char = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
   endfunction

   assign cp        = req_data.code_point;
   assign req_ready = queue_space;
   assign push      = req_valid & queue_space;
   assign csr_ready = 1'b1;

   // escape or UTF-8 encode one scalar
   always_comb begin
      esc     = '0;
      esc_len = 3'd1;
      case (cp)
         21'h22: begin esc[0] = CHAR_BACKSLASH; esc[1] = CHAR_QUOTE;     esc_len = 3'd2; end
         21'h5c: begin esc[0] = CHAR_BACKSLASH; esc[1] = CHAR_BACKSLASH; esc_len = 3'd2; end
         21'h08: begin esc[0] = CHAR_BACKSLASH; esc[1] = 8'h62;          esc_len = 3'd2; end
         21'h0c: begin esc[0] = CHAR_BACKSLASH; esc[1] = 8'h66;          esc_len = 3'd2; end
         21'h0a: begin esc[0] = CHAR_BACKSLASH; esc[1] = 8'h6e;          esc_len = 3'd2; end
         21'h0d: begin esc[0] = CHAR_BACKSLASH; esc[1] = 8'h72;          esc_len = 3'd2; end
         21'h09: begin esc[0] = CHAR_BACKSLASH; esc[1] = 8'h74;          esc_len = 3'd2; end
         default: begin
            if (cp < 21'h20) begin
               esc[0]  = CHAR_BACKSLASH;
               esc[1]  = 8'h75;
               esc[2]  = 8'h30;
               esc[3]  = 8'h30;
               esc[4]  = hex_char({3'b000, cp[4]});
               esc[5]  = hex_char(cp[3:0]);
               esc_len = 3'd6;
            end else if (cp <= 21'h7f) begin
               esc[0]  = cp[7:0];
               esc_len = 3'd1;
            end else if (cp <= 21'h7ff) begin
               esc[0]  = {3'b110, cp[10:6]};
               esc[1]  = {2'b10, cp[5:0]};
               esc_len = 3'd2;
            end else if (cp <= 21'hffff) begin
               esc[0]  = {4'b1110, cp[15:12]};
               esc[1]  = {2'b10, cp[11:6]};
               esc[2]  = {2'b10, cp[5:0]};
               esc_len = 3'd3;
            end else begin
               esc[0]  = {5'b11110, cp[20:18]};
               esc[1]  = {2'b10, cp[17:12]};
               esc[2]  = {2'b10, cp[11:6]};
               esc[3]  = {2'b10, cp[5:0]};
               esc_len = 3'd4;
            end
         end
      endcase
   end

   // limit checks and run assembly
   always_comb begin
      logic                   clear;
      logic [COUNT_WIDTH-1:0] bc;
      logic [COUNT_WIDTH-1:0] wc;
      status_type             err_prev;
      logic [CALC_WIDTH-1:0]  cap;
      logic [CALC_WIDTH-1:0]  wl;
      logic [CALC_WIDTH-1:0]  rem;
      logic [3:0]             rem_small;
      logic                   open_q;
      logic                   close_q;
      logic [5:0][7:0]        mid;
      logic [3:0]             mid_len;
      logic [3:0]             a2;
      logic [3:0]             a3;
      logic [3:0]             good;
      logic [3:0]             last;
      logic                   failed;
      status_type             fail_status;
      logic [RUN_BYTES-1:0][7:0] full;
      int                     j;

      clear    = req_data.starts_string | req_data.empty_string;
      bc       = clear ? '0 : byte_count_ff;
      wc       = clear ? '0 : work_count_ff;
      err_prev = clear ? STATUS_OK : error_latched_ff;

      cap = (CALC_WIDTH'(output_byte_limit_ff) < COUNT_MAX) ?
            CALC_WIDTH'(output_byte_limit_ff) : COUNT_MAX;
      wl  = (CALC_WIDTH'(work_limit_ff) < COUNT_MAX) ? CALC_WIDTH'(work_limit_ff) : COUNT_MAX;
      rem = (CALC_WIDTH'(bc) > cap) ? '0 : cap - CALC_WIDTH'(bc);
      rem_small = (rem > CALC_WIDTH'(15)) ? 4'd15 : rem[3:0];

      // an empty string is an opening quote followed by one more quote append
      mid = esc;
      mid_len = {1'b0, esc_len};
      open_q  = req_data.starts_string;
      close_q = req_data.ends_string;
      if (req_data.empty_string) begin
         mid     = '0;
         mid[0]  = CHAR_QUOTE;
         mid_len = 4'd1;
         open_q  = 1'b1;
         close_q = 1'b0;
      end
      a2 = {3'b000, open_q} + mid_len;
      a3 = a2 + {3'b000, close_q};

      work_count_in    = work_count_ff;
      byte_count_in    = byte_count_ff;
      error_latched_in = error_latched_ff;
      failed      = 1'b0;
      fail_status = STATUS_OK;
      good        = 4'd0;

      if (err_prev != STATUS_OK) begin
         // latched error: report it again, change nothing
         failed      = 1'b1;
         fail_status = err_prev;
      end else begin
         work_count_in    = wc;
         byte_count_in    = bc;
         error_latched_in = STATUS_OK;
         if (!req_data.empty_string && CALC_WIDTH'(wc) >= wl) begin
            failed      = 1'b1;
            fail_status = STATUS_LIMIT;
         end else begin
            if (!req_data.empty_string) begin
               work_count_in = wc + COUNT_WIDTH'(1);
            end
            if (!req_data.empty_string &&
                (cp > 21'h10ffff || (cp >= 21'hd800 && cp <= 21'hdfff))) begin
               failed      = 1'b1;
               fail_status = STATUS_MALFORMED;
            end else if (open_q && rem_small < 4'd1) begin
               failed      = 1'b1;
               fail_status = STATUS_LIMIT;
            end else if (rem_small < a2) begin
               good        = {3'b000, open_q};
               failed      = 1'b1;
               fail_status = STATUS_LIMIT;
            end else if (close_q && rem_small < a3) begin
               good        = a2;
               failed      = 1'b1;
               fail_status = STATUS_LIMIT;
            end else begin
               good = a3;
            end
            byte_count_in = bc + COUNT_WIDTH'(good);
            if (failed) begin
               error_latched_in = fail_status;
            end
         end
      end

      for (int i = 0; i < RUN_BYTES; i++) begin
         j = i - int'(open_q);
         if (open_q && i == 0) begin
            full[i] = CHAR_QUOTE;
         end else if (j < int'(mid_len)) begin
            full[i] = mid[j[2:0]];
         end else if (close_q && j == int'(mid_len)) begin
            full[i] = CHAR_QUOTE;
         end else begin
            full[i] = 8'h00;
         end
         push_data.bytes[i] = (i < int'(good)) ? full[i] : 8'h00;
      end

      last = failed ? good : (good - 4'd1);
      push_data.last_idx = last[IDX_WIDTH-1:0];
      push_data.status   = failed ? fail_status : STATUS_OK;
   end

   // configuration writes
   always_comb begin
      output_byte_limit_in = output_byte_limit_ff;
      work_limit_in        = work_limit_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_OUTPUT_BYTE_LIMIT: output_byte_limit_in = csr_data;
            CSR_WORK_LIMIT:        work_limit_in        = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         output_byte_limit_ff <= '1;
         work_limit_ff        <= '1;
         byte_count_ff        <= '0;
         work_count_ff        <= '0;
         error_latched_ff     <= STATUS_OK;
      end else begin
         output_byte_limit_ff <= output_byte_limit_in;
         work_limit_ff        <= work_limit_in;
         if (push) begin
            byte_count_ff    <= byte_count_in;
            work_count_ff    <= work_count_in;
            error_latched_ff <= error_latched_in;
         end
      end
   end

endmodule

// File: rtl/core/jsonesc_queue.sv
// Small run queue between front end and back end.
module jsonesc_queue import jsonesc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  run_type push_data,
   output logic    space,
   input  logic    pop,
   output logic    head_valid,
   output run_type head_data
);

   run_type                entries_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QCNT_WIDTH-1:0]  count_ff, count_in;

   assign space      = (count_ff != QCNT_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> space)
      else $error("queue written while full");
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("queue read while empty");

endmodule

// File: rtl/core/jsonesc_back.sv
// Back end: plays out each run one result per cycle while rsp_ready is high.
module jsonesc_back import jsonesc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  run_type head_data,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   run_type              cur_ff, cur_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic [IDX_WIDTH-1:0] idx_ff, idx_in;
   logic                 at_last;
   logic                 load;

   assign at_last   = (idx_ff == cur_ff.last_idx);
   assign rsp_valid = cur_valid_ff;
   assign rsp_data.out_byte    = cur_ff.bytes[idx_ff];
   assign rsp_data.last_of_run = at_last;
   assign rsp_data.status      = at_last ? cur_ff.status : STATUS_OK;

   // take the next run once the current one is fully delivered
   assign load = !cur_valid_ff || (rsp_ready && at_last);
   assign pop  = load && head_valid;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_in       = head_data;
         cur_valid_in = head_valid;
         idx_in       = '0;
      end else if (rsp_ready) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> idx_ff <= cur_ff.last_idx)
      else $error("result index ran past the end of its run");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |->
         (rsp_data.last_of_run && rsp_data.out_byte == 8'h00))
      else $error("error result not last or carries a byte");

endmodule

// File: rtl/core/json_string_escape_utf8_encoder.sv
// An accepted item's run is registered in the queue, then in the output stage, before its first result shows.
// Throughput: one item per cycle while each item yields one result (plain ASCII) and rsp_ready stays high.
// An item with several results holds the output until all are taken; the two-run queue then fills and stalls req.
// Output rate is one result per cycle while rsp_ready is high, set by the single byte output stage.
// Reset (synchronous): counters and sticky error clear, both limits go to all ones, queue empties.
module json_string_escape_utf8_encoder import jsonesc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  csr_index_type          csr_index,
   input  logic [LIMIT_WIDTH-1:0] csr_data
);

   // front to queue
   logic    push;
   run_type push_data;
   logic    queue_space;

   // queue to back
   logic    pop;
   logic    head_valid;
   run_type head_data;

   // Front: classify each item, check work and byte limits, update the counters
   // and sticky error, and build the whole run of result bytes combinationally.
   jsonesc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_space (queue_space),
      .push        (push),
      .push_data   (push_data)
   );

   // Queue: hold finished runs so the front keeps accepting while results drain.
   jsonesc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .space      (queue_space),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // Back: advance through the current run one result per cycle while rsp_ready is high, then load the next.
   jsonesc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// File: test/json_string_escape_utf8_encoder_tb.sv
// Self-checking testbench for the JSON string escaper and UTF-8 encoder.
module json_string_escape_utf8_encoder_tb;
   import jsonesc_pkg::*;

   // Scalar range bounds and the all-ones limit value
   localparam logic [CP_WIDTH-1:0]    SCALAR_MAX = 21'h10ffff;
   localparam logic [CP_WIDTH-1:0]    SURR_LO    = 21'h00d800;
   localparam logic [CP_WIDTH-1:0]    SURR_HI    = 21'h00dfff;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_ALL  = '1;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index = CSR_OUTPUT_BYTE_LIMIT;
   logic [LIMIT_WIDTH-1:0] csr_data  = '0;

   json_string_escape_utf8_encoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Code points waiting to be offered, and the bytes the encoder owes us
   req_type codepoint_q [$];
   rsp_type pending_bytes [$];

   // Shadow state of the encoder
   longint unsigned byte_total, work_total;
   longint unsigned byte_cap = 64'(LIMIT_ALL);
   longint unsigned work_cap = 64'(LIMIT_ALL);
   status_type      sticky_err = STATUS_OK;

   // Run statistics
   int n_items, n_results, n_err_results, n_csr, mismatches;

   // Handshake helpers for the two sides
   logic req_fire;
   int   req_gap, req_calm, rsp_stall, rsp_calm;
   rsp_type want;

   // Mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      return (v < 4'd10) ? 8'h30 + v : 8'h57 + v;
   endfunction

   // Escape or UTF-8 encode one valid scalar; return the byte count
   function automatic int utf8_escape(input logic [CP_WIDTH-1:0] s,
                                      output logic [5:0][7:0] seq);
      seq = '0;
      case (s)
         21'h22: begin seq[0] = CHAR_BACKSLASH; seq[1] = CHAR_QUOTE;     return 2; end
         21'h5c: begin seq[0] = CHAR_BACKSLASH; seq[1] = CHAR_BACKSLASH; return 2; end
         21'h08: begin seq[0] = CHAR_BACKSLASH; seq[1] = "b"; return 2; end
         21'h0c: begin seq[0] = CHAR_BACKSLASH; seq[1] = "f"; return 2; end
         21'h0a: begin seq[0] = CHAR_BACKSLASH; seq[1] = "n"; return 2; end
         21'h0d: begin seq[0] = CHAR_BACKSLASH; seq[1] = "r"; return 2; end
         21'h09: begin seq[0] = CHAR_BACKSLASH; seq[1] = "t"; return 2; end
         default: begin
            if (s < 21'h20) begin
               seq[0] = CHAR_BACKSLASH;
               seq[1] = "u";
               seq[2] = "0";
               seq[3] = "0";
               seq[4] = hex_digit({3'b000, s[4]});
               seq[5] = hex_digit(s[3:0]);
               return 6;
            end else if (s <= 21'h7f) begin
               seq[0] = s[7:0];
               return 1;
            end else if (s <= 21'h7ff) begin
               seq[0] = 8'hc0 | s[10:6];
               seq[1] = 8'h80 | s[5:0];
               return 2;
            end else if (s <= 21'hffff) begin
               seq[0] = 8'he0 | s[15:12];
               seq[1] = 8'h80 | s[11:6];
               seq[2] = 8'h80 | s[5:0];
               return 3;
            end
            seq[0] = 8'hf0 | s[20:18];
            seq[1] = 8'h80 | s[17:12];
            seq[2] = 8'h80 | s[11:6];
            seq[3] = 8'h80 | s[5:0];
            return 4;
         end
      endcase
   endfunction

   task automatic put_byte(input logic [7:0] b, input status_type st);
      pending_bytes.push_back('{out_byte: b, last_of_run: 1'b0, status: st});
   endtask

   task automatic flag_error(input status_type st);
      sticky_err = st;
      put_byte(8'h00, st);
   endtask

   // All or nothing: a refused append emits only the limit error
   task automatic append_seq(input logic [5:0][7:0] seq, input int n, output bit ok);
      longint unsigned cap = (byte_cap < COUNT_MAX) ? byte_cap : COUNT_MAX;
      if (byte_total > cap || longint'(n) > cap - byte_total) begin
         flag_error(STATUS_LIMIT);
         ok = 1'b0;
      end else begin
         for (int i = 0; i < n; i++) put_byte(seq[i], STATUS_OK);
         byte_total += n;
         ok = 1'b1;
      end
   endtask

   task automatic append_quote(output bit ok);
      logic [5:0][7:0] seq = '0;
      seq[0] = CHAR_QUOTE;
      append_seq(seq, 1, ok);
   endtask

   // Work out every byte (or error) that one accepted code point must produce
   task automatic escape_item(input req_type it);
      logic [5:0][7:0] seq;
      longint unsigned work_eff;
      int  n, first;
      bit  ok, done;
      first = pending_bytes.size();
      done = 1'b0;
      ok = 1'b1;
      work_eff = (work_cap < COUNT_MAX) ? work_cap : COUNT_MAX;
      if (it.starts_string || it.empty_string) begin
         byte_total = 0;
         work_total = 0;
         sticky_err = STATUS_OK;
      end else if (sticky_err != STATUS_OK) begin
         // sticky error: report it again, change nothing
         put_byte(8'h00, sticky_err);
         done = 1'b1;
      end
      if (!done && it.empty_string) begin
         append_quote(ok);
         if (ok) append_quote(ok);
         done = 1'b1;
      end
      if (!done && work_total >= work_eff) begin
         flag_error(STATUS_LIMIT);
         done = 1'b1;
      end
      if (!done) begin
         // a malformed scalar still costs its work unit
         work_total++;
         if (it.code_point > SCALAR_MAX ||
             (it.code_point >= SURR_LO && it.code_point <= SURR_HI)) begin
            flag_error(STATUS_MALFORMED);
            done = 1'b1;
         end
      end
      if (!done && it.starts_string) begin
         append_quote(ok);
         done = !ok;
      end
      if (!done) begin
         n = utf8_escape(it.code_point, seq);
         append_seq(seq, n, ok);
         done = !ok;
      end
      if (!done && it.ends_string) append_quote(ok);
      if (pending_bytes.size() == first) put_byte(8'h00, sticky_err);
      pending_bytes[pending_bytes.size() - 1].last_of_run = 1'b1;
   endtask

   task automatic queue_item(input logic [CP_WIDTH-1:0] cp, input bit s, input bit e,
                             input bit m);
      req_type it;
      it.code_point    = cp;
      it.starts_string = s;
      it.ends_string   = e;
      it.empty_string  = m;
      codepoint_q.push_back(it);
   endtask

   // Pick a code point from one of several classes, boundaries included
   function automatic logic [CP_WIDTH-1:0] rand_scalar();
      case ($urandom_range(0, 9))
         0: return CP_WIDTH'($urandom_range(0, 21'h1f));
         1: begin
            case ($urandom_range(0, 6))
               0: return 21'h22;
               1: return 21'h5c;
               2: return 21'h08;
               3: return 21'h0c;
               4: return 21'h0a;
               5: return 21'h0d;
               default: return 21'h09;
            endcase
         end
         2, 3: return CP_WIDTH'($urandom_range(21'h20, 21'h7f));
         4: return CP_WIDTH'($urandom_range(21'h80, 21'h7ff));
         5: return CP_WIDTH'($urandom_range(21'h800, 21'hffff));
         6: return CP_WIDTH'($urandom_range(21'h10000, SCALAR_MAX));
         7: begin
            case ($urandom_range(0, 8))
               0: return 21'h7f;
               1: return 21'h80;
               2: return 21'h7ff;
               3: return 21'h800;
               4: return 21'hd7ff;
               5: return 21'he000;
               6: return 21'hffff;
               7: return 21'h10000;
               default: return SCALAR_MAX;
            endcase
         end
         8: begin
            if ($urandom_range(0, 1) == 0) return CP_WIDTH'($urandom_range(SURR_LO, SURR_HI));
            return CP_WIDTH'($urandom_range(SCALAR_MAX + 21'd1, 21'h1fffff));
         end
         default: return CP_WIDTH'($urandom_range(0, 21'h1fffff));
      endcase
   endfunction

   // Mostly well-formed strings, with some noise and some strings left open
   task automatic random_phase(input int target);
      int added = 0;
      int len;
      bit open_end;
      while (added < target) begin
         if ($urandom_range(0, 99) < 12) begin
            queue_item(CP_WIDTH'($urandom_range(0, 21'h1fffff)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            added++;
         end else begin
            len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
            if (len == 0) begin
               queue_item(rand_scalar(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'b1);
               added++;
            end else begin
               open_end = ($urandom_range(0, 9) == 0);
               for (int i = 0; i < len; i++) begin
                  queue_item(rand_scalar(), i == 0, (i == len - 1) && !open_end, 1'b0);
                  added++;
               end
            end
         end
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [LIMIT_WIDTH-1:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_OUTPUT_BYTE_LIMIT) byte_cap = 64'(val);
      else work_cap = 64'(val);
      n_csr++;
   endtask

   // Write both limits; only called while the encoder is idle
   task automatic set_limits(input logic [LIMIT_WIDTH-1:0] byte_lim,
                             input logic [LIMIT_WIDTH-1:0] work_lim);
      write_reg(CSR_OUTPUT_BYTE_LIMIT, byte_lim);
      write_reg(CSR_WORK_LIMIT, work_lim);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Every item yields at least one result, so an empty store means idle;
   // look at the rising edge, where the driver's outputs are settled
   task automatic drain();
      while (codepoint_q.size() != 0 || req_valid || pending_bytes.size() != 0)
         @(posedge clock);
   endtask

   // Input driver: hold until accepted, then idle for the drawn gap, then offer the next
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // hold the item and its payload
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap   <= req_gap - 1;
      end else if (codepoint_q.size() > 0) begin
         req_data  <= codepoint_q.pop_front();
         req_valid <= 1'b1;
         if (req_calm > 0) begin
            req_calm <= req_calm - 1;
            req_gap  <= 0;
         end else begin
            req_gap <= idle_len();
            if ($urandom_range(0, 19) == 0) req_calm <= $urandom_range(10, 40);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result side: stall at random, with occasional stretches of steady ready
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_calm > 0) rsp_calm <= rsp_calm - 1;
         else if ($urandom_range(0, 3) == 0) rsp_stall <= idle_len();
         else if ($urandom_range(0, 49) == 0) rsp_calm <= $urandom_range(20, 60);
      end
   end

   // Predict at each accepted item
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            escape_item(req_data);
            n_items++;
         end
      end
   end

   // Compare each accepted result with the oldest expected byte
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: byte %02h last %0b status %0d",
                        rsp_data.out_byte, rsp_data.last_of_run, rsp_data.status);
         end else begin
            want = pending_bytes.pop_front();
            n_results++;
            if (want.status != STATUS_OK) n_err_results++;
            if (rsp_data.out_byte !== want.out_byte ||
                rsp_data.last_of_run !== want.last_of_run ||
                rsp_data.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected byte %02h last %0b status %0d, got %02h %0b %0d",
                           want.out_byte, want.last_of_run, want.status,
                           rsp_data.out_byte, rsp_data.last_of_run, rsp_data.status);
            end
         end
      end
   end

   initial begin
      int unsigned ladder [$];
      ladder = '{32'h1f, 32'h08, 32'h0c, 32'h0a, 32'h0d, 32'h09, 32'h22, 32'h5c,
                 32'h20, 32'h7f, 32'h80, 32'h7ff, 32'h800, 32'hffff, 32'h10000, 32'h10ffff};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset limits: flags, escapes, every UTF-8 length and its boundaries
      queue_item(21'h1fffff, 1'b1, 1'b1, 1'b1);   // empty string wins over the other flags
      queue_item(21'h000000, 1'b1, 1'b0, 1'b0);
      foreach (ladder[i])
         queue_item(ladder[i][CP_WIDTH-1:0], 1'b0, i == ladder.size() - 1, 1'b0);
      queue_item(21'h41, 1'b1, 1'b1, 1'b0);
      queue_item(21'h42, 1'b0, 1'b0, 1'b0);       // trails a closed string
      queue_item(21'h01, 1'b1, 1'b1, 1'b0);       // quote, six-byte escape, quote
      queue_item(SURR_LO, 1'b1, 1'b0, 1'b0);      // malformed, then sticky
      queue_item(21'h43, 1'b0, 1'b1, 1'b0);
      queue_item(SURR_HI, 1'b1, 1'b1, 1'b0);
      queue_item(SCALAR_MAX + 21'd1, 1'b1, 1'b0, 1'b0);
      queue_item(21'h1fffff, 1'b1, 1'b1, 1'b0);
      drain();

      // Byte limit of one: the opening quote fits, nothing else does
      set_limits(32'd1, LIMIT_ALL);
      queue_item(21'h41, 1'b1, 1'b0, 1'b0);
      queue_item(21'h42, 1'b0, 1'b0, 1'b0);
      queue_item(21'h00, 1'b0, 1'b0, 1'b1);
      drain();

      // Zero limits refuse everything
      set_limits(32'd0, 32'd0);
      queue_item(21'h41, 1'b1, 1'b0, 1'b0);
      queue_item(21'h00, 1'b0, 1'b0, 1'b1);
      drain();

      set_limits(LIMIT_ALL, 32'd1);
      queue_item(21'h61, 1'b1, 1'b0, 1'b0);
      queue_item(21'h62, 1'b0, 1'b0, 1'b0);
      drain();

      // Lower the byte limit below what an open string already holds
      set_limits(LIMIT_ALL, LIMIT_ALL);
      queue_item(21'h61, 1'b1, 1'b0, 1'b0);
      for (int c = 21'h62; c <= 21'h65; c++) queue_item(CP_WIDTH'(c), 1'b0, 1'b0, 1'b0);
      drain();
      set_limits(32'd3, LIMIT_ALL);
      queue_item(21'h66, 1'b0, 1'b0, 1'b0);
      drain();

      // Same for the work limit
      set_limits(LIMIT_ALL, LIMIT_ALL);
      queue_item(21'h61, 1'b1, 1'b0, 1'b0);
      queue_item(21'h62, 1'b0, 1'b0, 1'b0);
      queue_item(21'h63, 1'b0, 1'b0, 1'b0);
      drain();
      set_limits(LIMIT_ALL, 32'd2);
      queue_item(21'h64, 1'b0, 1'b0, 1'b0);
      drain();

      // Random strings under several limit settings
      set_limits(LIMIT_ALL, LIMIT_ALL);
      random_phase(60);
      drain();
      set_limits($urandom_range(4, 30), $urandom_range(2, 10));
      random_phase(55);
      drain();
      set_limits(LIMIT_ALL, $urandom_range(1, 6));
      random_phase(55);
      drain();
      set_limits($urandom_range(1, 12), 32'h8000_0000);
      random_phase(60);
      drain();

      // Let any stray result show up
      repeat (20) @(posedge clock);

      $display("covered %0d code points, %0d results checked, %0d of them errors",
               n_items, n_results, n_err_results);
      $display("%0d limit register writes, %0d mismatches", n_csr, mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/jsonesc_pkg.sv
rtl/core/jsonesc_front.sv
rtl/core/jsonesc_queue.sv
rtl/core/jsonesc_back.sv
rtl/core/json_string_escape_utf8_encoder.sv
test/json_string_escape_utf8_encoder_tb.sv
